FILE: hdl/olist_pkg.sv
// shared constants, request codes and types for the ordered list engine
package olist_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int CNT_W    = 7;
    localparam int REQ_W    = 4;
    localparam int STAT_W   = 2;

    // two-level select tree: groups of GRP cells, NGRP groups
    localparam int GRP  = 8;
    localparam int NGRP = CAPACITY / GRP;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD_HEAD   = 4'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_TAIL   = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 4'd2;
    localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_REM_HEAD   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_REM_AT     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_REM_TAIL   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ       = 4'd7;
    localparam logic [REQ_W-1:0] REQ_FIND       = 4'd8;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              upd;
        logic              ins;
        logic              find;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] key;
    } cell_ctrl_t;

    // one select tree result
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } pick_t;

endpackage

FILE: hdl/olist_req_if.sv
// request channel of the ordered list engine
interface olist_req_if;
    logic                                valid;
    logic                                ready;
    logic [olist_pkg::REQ_W-1:0]         req_type;
    logic [olist_pkg::POS_W-1:0]         position;
    logic signed [olist_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input item_value,
                    output ready);
endinterface

FILE: hdl/olist_rsp_if.sv
// result channel of the ordered list engine
interface olist_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [olist_pkg::STAT_W-1:0]        status;
    logic signed [olist_pkg::DATA_W-1:0] result_value;
    logic [olist_pkg::IDX_W-1:0]         found_position;
    logic [olist_pkg::CNT_W-1:0]         item_count;
    logic                                list_empty;

    modport source (output valid, output status, output result_value,
                    output found_position, output item_count, output list_empty,
                    input ready);
    modport sink   (input valid, input status, input result_value,
                    input found_position, input item_count, input list_empty,
                    output ready);
endinterface

FILE: hdl/olist_cell.sv
// one list entry: holds a value, shifts with its neighbours, flags a match
module olist_cell (
    input  logic                           clk,
    input  logic [olist_pkg::IDX_W-1:0]    idx,
    input  olist_pkg::cell_ctrl_t          ctrl,
    input  logic [olist_pkg::DATA_W-1:0]   left_value,
    input  logic [olist_pkg::DATA_W-1:0]   right_value,
    output logic [olist_pkg::DATA_W-1:0]   value,
    output logic                           hit
);

    logic [olist_pkg::DATA_W-1:0] value_reg;
    logic [olist_pkg::DATA_W-1:0] value_next;
    logic [olist_pkg::POS_W-1:0]  my_pos;

    assign my_pos = olist_pkg::POS_W'(idx);
    assign value  = value_reg;

    // match on value for a find, on position otherwise
    always_comb
    begin
        if (ctrl.find)
            hit = (my_pos < ctrl.count) && (value_reg == ctrl.key);
        else
            hit = (my_pos == ctrl.pos);
    end

    // insert pulls from the left, remove pulls from the right
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.upd)
        begin
            if (ctrl.ins)
            begin
                if (my_pos > ctrl.pos)
                    value_next = left_value;
                else if (my_pos == ctrl.pos)
                    value_next = ctrl.key;
            end
            else if (my_pos >= ctrl.pos)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: hdl/olist_pick.sv
// registered priority select over one group of candidates, lowest index wins
module olist_pick (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic [olist_pkg::GRP-1:0]                 hit,
    input  logic [olist_pkg::GRP-1:0][olist_pkg::IDX_W-1:0]  idx,
    input  logic [olist_pkg::GRP-1:0][olist_pkg::DATA_W-1:0] value,
    output olist_pkg::pick_t                          pick
);

    olist_pkg::pick_t pick_reg;
    olist_pkg::pick_t pick_next;

    assign pick = pick_reg;

    // scan from the top so the lowest hit is left standing
    always_comb
    begin
        pick_next = '0;
        for (int k = olist_pkg::GRP - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                pick_next.hit   = 1'b1;
                pick_next.idx   = idx[k];
                pick_next.value = value[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pick_reg <= '0;
        else if (en)
            pick_reg <= pick_next;
    end

endmodule

FILE: hdl/ordered_list_engine.sv
// ordered list engine: a row of entry cells, a two-level select tree and a sequencer
// an accepted request walks the sequencer through the hit, select and output states
//   (cell compare and group select, final select, shift and result), and a new request
//   is taken only back in idle; the output state waits while the result register is full
// reset: asynchronous active low, clears the count and the handshake state;
//   entry values are not cleared, only entries below the count are ever read
module ordered_list_engine (
    input  logic         clk,
    input  logic         rst_n,
    olist_req_if.sink    req,
    olist_rsp_if.source  rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HIT  = 2'd1;
    localparam logic [1:0] S_SEL  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // latched request
    logic [olist_pkg::REQ_W-1:0]  type_reg;
    logic [olist_pkg::POS_W-1:0]  pos_reg;
    logic [olist_pkg::DATA_W-1:0] val_reg;

    logic [olist_pkg::CNT_W-1:0]  count_reg;
    logic [olist_pkg::CNT_W-1:0]  count_next;

    // result register
    logic                          out_valid_reg;
    logic [olist_pkg::STAT_W-1:0]  out_status_reg;
    logic [olist_pkg::DATA_W-1:0]  out_value_reg;
    logic [olist_pkg::IDX_W-1:0]   out_found_reg;
    logic [olist_pkg::CNT_W-1:0]   out_count_reg;

    logic req_fire;
    logic out_free;
    logic finish;

    olist_pkg::cell_ctrl_t ctrl;
    logic                          do_upd;
    logic                          is_ins;
    logic [olist_pkg::POS_W-1:0]   tgt_pos;
    logic [olist_pkg::STAT_W-1:0]  status_d;
    logic [olist_pkg::DATA_W-1:0]  value_d;
    logic [olist_pkg::IDX_W-1:0]   found_d;
    logic                          use_pick;
    logic [olist_pkg::POS_W-1:0]   eff_pos;
    logic                          full;

    logic [olist_pkg::CAPACITY-1:0]                          hits;
    logic [olist_pkg::CAPACITY-1:0][olist_pkg::DATA_W-1:0]   values;
    logic [olist_pkg::CAPACITY-1:0][olist_pkg::IDX_W-1:0]    cell_idx;

    olist_pkg::pick_t [olist_pkg::NGRP-1:0]                  grp_pick;
    logic [olist_pkg::NGRP-1:0]                              grp_hit;
    logic [olist_pkg::NGRP-1:0][olist_pkg::IDX_W-1:0]        grp_idx;
    logic [olist_pkg::NGRP-1:0][olist_pkg::DATA_W-1:0]       grp_value;
    olist_pkg::pick_t                                        fin_pick;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == S_OUT) && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_fire) state_next = S_HIT;
            S_HIT:   state_next = S_SEL;
            S_SEL:   state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            type_reg <= req.req_type;
            pos_reg  <= req.position;
            val_reg  <= req.item_value;
        end
    end

    // decode the request against the current count
    always_comb
    begin
        full     = (count_reg == olist_pkg::CNT_W'(olist_pkg::CAPACITY));
        do_upd   = 1'b0;
        is_ins   = 1'b0;
        tgt_pos  = pos_reg;
        status_d = olist_pkg::ST_OK;
        use_pick = 1'b0;
        eff_pos  = pos_reg;
        case (type_reg)
            olist_pkg::REQ_ADD_HEAD, olist_pkg::REQ_ADD_TAIL,
            olist_pkg::REQ_INS_BEFORE, olist_pkg::REQ_INS_AFTER:
            begin
                is_ins = 1'b1;
                if (type_reg == olist_pkg::REQ_ADD_HEAD)
                    tgt_pos = '0;
                else if (type_reg == olist_pkg::REQ_ADD_TAIL || pos_reg >= count_reg)
                    tgt_pos = count_reg;
                else if (type_reg == olist_pkg::REQ_INS_BEFORE)
                    tgt_pos = pos_reg;
                else
                    tgt_pos = pos_reg + 1'b1;
                if (full)
                    status_d = olist_pkg::ST_FULL;
                else
                    do_upd = 1'b1;
            end
            olist_pkg::REQ_REM_HEAD, olist_pkg::REQ_REM_AT,
            olist_pkg::REQ_REM_TAIL, olist_pkg::REQ_READ:
            begin
                if (type_reg == olist_pkg::REQ_REM_HEAD)
                    eff_pos = '0;
                else if (type_reg == olist_pkg::REQ_REM_TAIL)
                    eff_pos = count_reg - 1'b1;
                tgt_pos = eff_pos;
                if (count_reg == '0 || eff_pos >= count_reg)
                begin
                    status_d = olist_pkg::ST_FAIL;
                end
                else
                begin
                    use_pick = 1'b1;
                    do_upd   = (type_reg != olist_pkg::REQ_READ);
                end
            end
            olist_pkg::REQ_FIND:
            begin
                if (!fin_pick.hit)
                    status_d = olist_pkg::ST_FAIL;
            end
            default:
            begin
                status_d = olist_pkg::ST_FAIL;
            end
        endcase
    end

    assign value_d = use_pick ? fin_pick.value : '0;
    assign found_d = (type_reg == olist_pkg::REQ_FIND && fin_pick.hit) ? fin_pick.idx : '0;

    // broadcast to the cells, shift only on the closing edge
    always_comb
    begin
        ctrl       = '0;
        ctrl.upd   = finish && do_upd;
        ctrl.ins   = is_ins;
        ctrl.find  = (type_reg == olist_pkg::REQ_FIND);
        ctrl.pos   = tgt_pos;
        ctrl.count = count_reg;
        ctrl.key   = val_reg;
    end

    // count follows the shift direction
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.upd)
        begin
            if (is_ins)
                count_next = count_reg + 1'b1;
            else
                count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // row of entry cells
    genvar g;
    generate
        for (g = 0; g < olist_pkg::CAPACITY; g++)
        begin : g_cell
            logic [olist_pkg::DATA_W-1:0] left_v;
            logic [olist_pkg::DATA_W-1:0] right_v;

            if (g == 0)
            begin : g_first
                assign left_v = '0;
            end
            else
            begin : g_left
                assign left_v = values[g-1];
            end

            if (g == olist_pkg::CAPACITY - 1)
            begin : g_last
                assign right_v = '0;
            end
            else
            begin : g_right
                assign right_v = values[g+1];
            end

            assign cell_idx[g] = olist_pkg::IDX_W'(g);

            olist_cell u_cell (
                .clk         (clk),
                .idx         (cell_idx[g]),
                .ctrl        (ctrl),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (values[g]),
                .hit         (hits[g])
            );
        end
    endgenerate

    // first tree level: one select per group of cells
    generate
        for (g = 0; g < olist_pkg::NGRP; g++)
        begin : g_grp
            olist_pick u_pick (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (state_reg == S_HIT),
                .hit   (hits[g*olist_pkg::GRP +: olist_pkg::GRP]),
                .idx   (cell_idx[g*olist_pkg::GRP +: olist_pkg::GRP]),
                .value (values[g*olist_pkg::GRP +: olist_pkg::GRP]),
                .pick  (grp_pick[g])
            );
            assign grp_hit[g]   = grp_pick[g].hit;
            assign grp_idx[g]   = grp_pick[g].idx;
            assign grp_value[g] = grp_pick[g].value;
        end
    endgenerate

    // second tree level over the group results
    olist_pick u_fin (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (state_reg == S_SEL),
        .hit   (grp_hit),
        .idx   (grp_idx),
        .value (grp_value),
        .pick  (fin_pick)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_status_reg <= status_d;
            out_value_reg  <= value_d;
            out_found_reg  <= found_d;
            out_count_reg  <= count_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_value   = out_value_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.item_count     = out_count_reg;
    assign rsp.list_empty     = (out_count_reg == '0);

`ifndef ASSERT_OFF
    // count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olist_pkg::CNT_W'(olist_pkg::CAPACITY))
        else $error("count beyond capacity");

    // the list only changes on the closing edge of a request
    a_count_edge: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == S_OUT))
        else $error("count changed outside the closing edge");

    // a fresh result only follows the closing step
    a_rsp_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the closing step");

    // the hit step leads to the select step, with no new request taken
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HIT) |=> (state_reg == S_SEL) && !req.ready)
        else $error("sequencer skipped a step");
`endif

endmodule

FILE: bench/tb.sv
// testbench for the ordered list engine: directed and random requests, queue predictor
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_PCT        = 29;
    localparam int RANDOM_REQUESTS = 600;
    localparam int PHASE_LEN       = 100;
    localparam int STEADY_FIRST    = 250;
    localparam int STEADY_LAST     = 350;
    localparam int DRAIN_POINT     = 300;
    localparam int SETTLE_CYCLES   = 16;
    localparam int MAX_CYCLES      = 400000;
    localparam int MAX_REPORTS     = 10;
    localparam int POS_MAX         = (1 << olist_pkg::POS_W) - 1;

    // insert share of each random phase: fill, hold at full, drain, mixed, drain, fill
    localparam int GROWTH_PCT [6] = '{70, 70, 10, 42, 10, 70};

    // highest request code, all codes above find are unused
    localparam logic [olist_pkg::REQ_W-1:0] REQ_TOP_UNUSED = '1;

    localparam logic signed [olist_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(olist_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [olist_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(olist_pkg::DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [olist_pkg::STAT_W-1:0]        status;
        logic signed [olist_pkg::DATA_W-1:0] result_value;
        logic [olist_pkg::IDX_W-1:0]         found_position;
        logic [olist_pkg::CNT_W-1:0]         item_count;
        logic                                list_empty;
    } list_result_t;

    // list contents predictor and store of outstanding results
    class list_scoreboard;
        logic signed [olist_pkg::DATA_W-1:0] contents[$];
        list_result_t                        pending[$];
        int                                  errors;

        function void note_request(logic [olist_pkg::REQ_W-1:0] kind,
                                   logic [olist_pkg::POS_W-1:0] pos,
                                   logic signed [olist_pkg::DATA_W-1:0] value);
            list_result_t r;
            int           n;
            int           at;
            bit           hit;
            r = '0;
            n = contents.size();
            case (kind)
                olist_pkg::REQ_ADD_HEAD, olist_pkg::REQ_ADD_TAIL,
                olist_pkg::REQ_INS_BEFORE, olist_pkg::REQ_INS_AFTER:
                begin
                    if (n >= olist_pkg::CAPACITY)
                    begin
                        r.status = olist_pkg::ST_FULL;
                    end
                    else
                    begin
                        // positions at or past the count append
                        if (kind == olist_pkg::REQ_ADD_HEAD)
                            at = 0;
                        else if (kind == olist_pkg::REQ_ADD_TAIL || int'(pos) >= n)
                            at = n;
                        else if (kind == olist_pkg::REQ_INS_BEFORE)
                            at = int'(pos);
                        else
                            at = int'(pos) + 1;
                        contents.insert(at, value);
                    end
                end
                olist_pkg::REQ_REM_HEAD, olist_pkg::REQ_REM_AT,
                olist_pkg::REQ_REM_TAIL, olist_pkg::REQ_READ:
                begin
                    if (kind == olist_pkg::REQ_REM_HEAD)
                        at = 0;
                    else if (kind == olist_pkg::REQ_REM_TAIL)
                        at = n - 1;
                    else
                        at = int'(pos);
                    if (n == 0 || at >= n)
                    begin
                        r.status = olist_pkg::ST_FAIL;
                    end
                    else
                    begin
                        r.result_value = contents[at];
                        if (kind != olist_pkg::REQ_READ)
                            contents.delete(at);
                    end
                end
                olist_pkg::REQ_FIND:
                begin
                    // first match wins
                    hit = 1'b0;
                    for (int i = 0; i < n && !hit; i++)
                    begin
                        if (contents[i] == value)
                        begin
                            hit = 1'b1;
                            r.found_position = olist_pkg::IDX_W'(i);
                        end
                    end
                    r.status = hit ? olist_pkg::ST_OK : olist_pkg::ST_FAIL;
                end
                default:
                begin
                    r.status = olist_pkg::ST_FAIL;
                end
            endcase
            r.item_count = olist_pkg::CNT_W'(contents.size());
            r.list_empty = (contents.size() == 0);
            pending.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            bit           bad;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d value %0d pos %0d count %0d empty %0b",
                             got.status, got.result_value, got.found_position,
                             got.item_count, got.list_empty);
                return;
            end
            want = pending.pop_front();
            bad = (got.status !== want.status) || (got.result_value !== want.result_value)
                || (got.found_position !== want.found_position)
                || (got.item_count !== want.item_count) || (got.list_empty !== want.list_empty);
            if (bad)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("mismatch: expected status %0d value %0d pos %0d count %0d empty %0b",
                             want.status, want.result_value, want.found_position,
                             want.item_count, want.list_empty);
                    $display("          actual   status %0d value %0d pos %0d count %0d empty %0b",
                             got.status, got.result_value, got.found_position,
                             got.item_count, got.list_empty);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    int   cycle_count = 0;

    list_scoreboard board;

    olist_req_if req_if ();
    olist_rsp_if rsp_if ();

    ordered_list_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // clock
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted results, random back-pressure
    always @(posedge clk)
    begin : result_sink
        list_result_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.status         = rsp_if.status;
            got.result_value   = rsp_if.result_value;
            got.found_position = rsp_if.found_position;
            got.item_count     = rsp_if.item_count;
            got.list_empty     = rsp_if.list_empty;
            board.check_result(got);
        end
        rsp_if.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // value to insert or search for, often one already held or a near duplicate
    function automatic logic signed [olist_pkg::DATA_W-1:0] pick_value();
        int n;
        int roll;
        n = board.contents.size();
        roll = $urandom_range(0, 99);
        if (roll < 35 && n > 0)
            return board.contents[$urandom_range(0, n - 1)];
        if (roll < 55)
            return olist_pkg::DATA_W'(int'($urandom_range(0, 8)) - 4);
        if (roll < 60)
            return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
        return $urandom();
    endfunction

    // mostly in range, some at the boundary, some anywhere in the field
    function automatic logic [olist_pkg::POS_W-1:0] pick_position(int n);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return olist_pkg::POS_W'($urandom_range(0, n));
        if (roll < 90)
            return olist_pkg::POS_W'($urandom_range(n, n + 2));
        return olist_pkg::POS_W'($urandom_range(0, POS_MAX));
    endfunction

    // one request, with random idle cycles ahead of it
    task automatic send_request(input logic [olist_pkg::REQ_W-1:0] kind,
                                input logic [olist_pkg::POS_W-1:0] pos,
                                input logic signed [olist_pkg::DATA_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.position   <= pos;
        req_if.item_value <= value;
        do
            @(posedge clk);
        while (!req_if.ready);
        board.note_request(kind, pos, value);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending.size() != 0);
    endtask

    // random request biased towards growing or shrinking the list
    task automatic random_request(input int grow_pct);
        int                          roll;
        int                          n;
        logic [olist_pkg::REQ_W-1:0] kind;
        n = board.contents.size();
        roll = $urandom_range(0, 99);
        if (roll < grow_pct)
            kind = olist_pkg::REQ_W'($urandom_range(olist_pkg::REQ_ADD_HEAD,
                                                    olist_pkg::REQ_INS_AFTER));
        else if (roll < 85)
            kind = olist_pkg::REQ_W'($urandom_range(olist_pkg::REQ_REM_HEAD,
                                                    olist_pkg::REQ_REM_TAIL));
        else if (roll < 97)
            kind = olist_pkg::REQ_W'($urandom_range(olist_pkg::REQ_READ,
                                                    olist_pkg::REQ_FIND));
        else
            kind = olist_pkg::REQ_W'($urandom_range(int'(olist_pkg::REQ_FIND) + 1,
                                                    int'(REQ_TOP_UNUSED)));
        send_request(kind, pick_position(n), pick_value());
    endtask

    // stimulus
    initial
    begin : stimulus
        board = new();
        steady = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = olist_pkg::REQ_ADD_HEAD;
        req_if.position = '0;
        req_if.item_value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every remove, read and find fails, unused codes fail
        send_request(olist_pkg::REQ_FIND, '0, '0);
        send_request(olist_pkg::REQ_REM_HEAD, '0, '0);
        send_request(olist_pkg::REQ_REM_TAIL, '0, '0);
        send_request(olist_pkg::REQ_REM_AT, '0, '0);
        send_request(olist_pkg::REQ_READ, '0, '0);
        send_request(olist_pkg::REQ_W'(olist_pkg::REQ_FIND + 1), '0, '0);
        send_request(REQ_TOP_UNUSED, olist_pkg::POS_W'(POS_MAX), '1);

        // inserts: head, tail, before head, append past the end, after a position
        send_request(olist_pkg::REQ_ADD_HEAD, '0, VAL_MAX);
        send_request(olist_pkg::REQ_ADD_TAIL, '0, VAL_MIN);
        send_request(olist_pkg::REQ_INS_BEFORE, '0, -1);
        send_request(olist_pkg::REQ_INS_BEFORE, olist_pkg::POS_W'(POS_MAX), '0);
        send_request(olist_pkg::REQ_INS_AFTER, '0, 5);
        send_request(olist_pkg::REQ_INS_AFTER, olist_pkg::POS_W'(olist_pkg::CAPACITY), 5);
        send_request(olist_pkg::REQ_INS_BEFORE, olist_pkg::POS_W'(2), 7);
        send_request(olist_pkg::REQ_INS_AFTER, olist_pkg::POS_W'(6), 3);

        // reads in and out of range, finds with duplicates and a miss
        send_request(olist_pkg::REQ_READ, '0, '0);
        send_request(olist_pkg::REQ_READ, olist_pkg::POS_W'(POS_MAX), '0);
        send_request(olist_pkg::REQ_READ, olist_pkg::POS_W'(8), '0);
        send_request(olist_pkg::REQ_FIND, '0, 5);
        send_request(olist_pkg::REQ_FIND, '0, VAL_MIN);
        send_request(olist_pkg::REQ_FIND, '0, 12345);

        // removes in the middle, out of range, tail and head
        send_request(olist_pkg::REQ_REM_AT, olist_pkg::POS_W'(3), '0);
        send_request(olist_pkg::REQ_REM_AT, olist_pkg::POS_W'(100), '0);
        send_request(olist_pkg::REQ_REM_TAIL, '0, '0);
        send_request(olist_pkg::REQ_REM_HEAD, '0, '0);
        drain_results();

        // random phases filling, holding full and draining the list
        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k == STEADY_FIRST)
                steady <= 1'b1;
            if (k == STEADY_LAST)
                steady <= 1'b0;
            if (k == DRAIN_POINT)
                drain_results();
            random_request(GROWTH_PCT[k / PHASE_LEN]);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
